[design/gbte_pkg.sv]
// ----------------------------------------------------------------------------
// gbte_pkg
// Shared types and constants for the two-stack gap buffer editor.
// ----------------------------------------------------------------------------
package gbte_pkg;

  localparam int CAPACITY = 4096;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [2:0] ACT_INSERT = 3'd0;
  localparam logic [2:0] ACT_LEFT   = 3'd1;
  localparam logic [2:0] ACT_DELETE = 3'd2;
  localparam logic [2:0] ACT_RIGHT  = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;

  localparam logic [1:0] STS_DONE = 2'd0;
  localparam logic [1:0] STS_EDGE = 2'd1;
  localparam logic [1:0] STS_FAIL = 2'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  ch;
    logic [11:0] position;
  } gbte_in_t;

  typedef struct packed {
    logic [7:0]  read_char;
    logic [1:0]  status;
    logic [12:0] text_length;
    logic [12:0] cursor;
  } gbte_out_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } gbte_state_t;

endpackage

[design/gap_buffer_text_editor.sv]
// ----------------------------------------------------------------------------
// gap_buffer_text_editor
// Cursor-editable byte buffer held as two stacks in two synchronous RAMs.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_word carry one action word: insert, cursor left,
//   delete before cursor, cursor right, or read a text position.
//   out_valid/out_stall/out_word return one result word per action: the read
//   byte, a status, the text length and the cursor after the action.
//   An accepted word's RAM bytes are registered at accept; its result is
//   registered when execute finds the output register free. The block
//   handles one action at a time and takes no new word until its action
//   leaves execute. The RAM read is issued at accept and the write-back
//   as execute completes. in_stall is high while an action executes.
//   A new word is accepted while a finished result still waits in the output
//   register; that action then holds in execute until the output register
//   is free, so a stalled receiver back-pressures the input after one word.
//   Reset clears the counts and the handshake state; RAM contents are left
//   as they are; a byte from an unwritten entry never reaches a result.
// ----------------------------------------------------------------------------
module gap_buffer_text_editor
  import gbte_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  gbte_in_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output gbte_out_t out_word
);

  logic [7:0] before_mem [CAPACITY];
  logic [7:0] after_mem  [CAPACITY];

  gbte_state_t state_r, state_nxt;
  logic [CNT_W-1:0] bc_r, bc_nxt;
  logic [CNT_W-1:0] ac_r, ac_nxt;
  gbte_in_t  item_r;
  gbte_out_t out_word_r, out_word_nxt;
  logic      out_valid_r, out_valid_nxt;

  logic [7:0] b_rdata_r, a_rdata_r;
  logic [ADDR_W-1:0] b_raddr, a_raddr;
  logic [CNT_W-1:0] pos_ext, in_pos_ext, len;
  logic accept, out_free, load;
  logic b_we, a_we;
  logic [ADDR_W-1:0] b_waddr, a_waddr;
  logic [7:0] b_wdata, a_wdata;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign load      = (state_r == ST_EXEC) && out_free;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign in_pos_ext = CNT_W'(in_word.position);
  assign pos_ext    = CNT_W'(item_r.position);
  assign len        = bc_r + ac_r;

  always_comb begin
    logic [CNT_W-1:0] a_off;
    a_off = ac_r + bc_r - CNT_W'(1) - in_pos_ext;
    if (in_word.action == ACT_READ) begin
      b_raddr = in_word.position;
      a_raddr = a_off[ADDR_W-1:0];
    end else begin
      b_raddr = ADDR_W'(bc_r - CNT_W'(1));
      a_raddr = ADDR_W'(ac_r - CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_rdata_r <= before_mem[b_raddr];
      a_rdata_r <= after_mem[a_raddr];
      item_r    <= in_word;
    end
    if (b_we) begin
      before_mem[b_waddr] <= b_wdata;
    end
    if (a_we) begin
      after_mem[a_waddr] <= a_wdata;
    end
  end

  always_comb begin
    bc_nxt       = bc_r;
    ac_nxt       = ac_r;
    b_we         = 1'b0;
    a_we         = 1'b0;
    b_waddr      = bc_r[ADDR_W-1:0];
    a_waddr      = ac_r[ADDR_W-1:0];
    b_wdata      = item_r.ch;
    a_wdata      = b_rdata_r;
    out_word_nxt = out_word_r;
    if (load) begin
      out_word_nxt.read_char = 8'd0;
      out_word_nxt.status    = STS_DONE;
      unique case (item_r.action)
        ACT_INSERT: begin
          if (len >= CNT_W'(CAPACITY)) begin
            out_word_nxt.status = STS_FAIL;
          end else begin
            b_we   = 1'b1;
            bc_nxt = bc_r + CNT_W'(1);
          end
        end
        ACT_LEFT: begin
          if (bc_r == '0 || ac_r >= CNT_W'(CAPACITY)) begin
            out_word_nxt.status = STS_EDGE;
          end else begin
            a_we   = 1'b1;
            bc_nxt = bc_r - CNT_W'(1);
            ac_nxt = ac_r + CNT_W'(1);
          end
        end
        ACT_DELETE: begin
          if (bc_r == '0) begin
            out_word_nxt.status = STS_EDGE;
          end else begin
            bc_nxt = bc_r - CNT_W'(1);
          end
        end
        ACT_RIGHT: begin
          if (ac_r == '0 || bc_r >= CNT_W'(CAPACITY)) begin
            out_word_nxt.status = STS_EDGE;
          end else begin
            b_we    = 1'b1;
            b_wdata = a_rdata_r;
            bc_nxt  = bc_r + CNT_W'(1);
            ac_nxt  = ac_r - CNT_W'(1);
          end
        end
        ACT_READ: begin
          if (pos_ext < bc_r) begin
            out_word_nxt.read_char = b_rdata_r;
          end else if (pos_ext < len) begin
            out_word_nxt.read_char = a_rdata_r;
          end else begin
            out_word_nxt.status = STS_FAIL;
          end
        end
        default: begin
          out_word_nxt.status = STS_FAIL;
        end
      endcase
      out_word_nxt.text_length = 13'(bc_nxt + ac_nxt);
      out_word_nxt.cursor      = 13'(bc_nxt);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bc_r        <= '0;
      ac_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bc_r        <= bc_nxt;
      ac_r        <= ac_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W + 1)'(bc_r) + (CNT_W + 1)'(ac_r) <= (CNT_W + 1)'(CAPACITY))
    else $error("text length exceeds capacity");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EXEC))
    else $error("accepted word did not enter execute");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r)
    else $error("executed action produced no result");

  a_counts_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !load |=> ($stable(bc_r) && $stable(ac_r)))
    else $error("counts changed outside execute");

endmodule
